### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of this block.
// Each macro takes a label, the clock, the active-low reset and a property
// or an expression. In synthesis they expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Check that an expression never holds outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

### rtl/core/svgl_pkg.sv
package svgl_pkg;

    localparam int PAYLOAD_MAX_DEF = 8;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [7:0] HDR_BYTE = 8'h55;
    localparam logic [7:0] CMD_RUN  = 8'h06;
    localparam logic [7:0] CMD_DONE = 8'h08;
    localparam logic [7:0] RUN_LEN  = 8'h05;
    localparam logic [7:0] NO_GROUP = 8'hFF;
    localparam logic [7:0] DONE_LEN = 8'd5;
    localparam logic [7:0] MIN_LEN  = 8'd2;

    typedef enum logic [1:0] {
        REQ_BYTE     = 2'd0,
        REQ_START    = 2'd1,
        REQ_TICK     = 2'd2,
        REQ_LINE_ERR = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ARG     = 2'd1,
        ST_TIMEOUT = 2'd2
    } t_status;

    typedef enum logic {
        K_FRAME  = 1'b0,
        K_STATUS = 1'b1
    } t_kind;

    // One unit of work for the back end: a run frame or a status report.
    typedef struct packed {
        t_kind       kind;
        t_status     status;
        logic [7:0]  group;
        logic [15:0] run_count;
        logic [7:0]  fin_group;
    } t_cmd;

endpackage

### rtl/core/servo_group_command_link.sv
// The first result beat of an input is offered once its command has been written
// into the queue and then loaded into the back end's command register.
// Throughput: one input beat per cycle while the command queue has room; the
// back end sends one result beat per cycle while the output is ready.
// Rate is set by the seven-beat run frame the back end serialises.
// Reset: synchronous, active low; clears parser, wait, queue, completed group 255.
module servo_group_command_link #(
    parameter int PAYLOAD_MAX = svgl_pkg::PAYLOAD_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_rx_byte,
    input  logic [7:0]  i_group,
    input  logic [15:0] i_run_count,
    input  logic        i_wait_for_done,
    input  logic [31:0] i_timeout_ms,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_result_kind,
    output logic [7:0]  o_tx_byte,
    output logic [1:0]  o_status,
    output logic [7:0]  o_finished_group,
    output logic        o_last
);

    // Front to queue: at most one command per accepted beat.
    logic           w_push_valid, w_push_ready;
    svgl_pkg::t_cmd w_push_data;
    // Queue to back end.
    logic           w_pop_valid, w_pop_ready;
    svgl_pkg::t_cmd w_pop_data;

    // Front: parse received bytes, keep the wait and timeout, classify each
    // beat into a run frame, a status report, or nothing.
    svgl_front #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_rx_byte       (i_rx_byte),
        .i_group         (i_group),
        .i_run_count     (i_run_count),
        .i_wait_for_done (i_wait_for_done),
        .i_timeout_ms    (i_timeout_ms),
        .o_push_valid    (w_push_valid),
        .o_push_data     (w_push_data),
        .i_push_ready    (w_push_ready)
    );

    // Short queue: lets the front keep taking beats while a frame drains.
    svgl_cmdq u_cmdq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_data),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_data)
    );

    // Back end: hold each command and advance through its result beats.
    svgl_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_pop_valid      (w_pop_valid),
        .o_pop_ready      (w_pop_ready),
        .i_pop_data       (w_pop_data),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_result_kind    (o_result_kind),
        .o_tx_byte        (o_tx_byte),
        .o_status         (o_status),
        .o_finished_group (o_finished_group),
        .o_last           (o_last)
    );

endmodule

### rtl/core/svgl_front.sv
`include "assert_macros.svh"

module svgl_front #(
    parameter int PAYLOAD_MAX = svgl_pkg::PAYLOAD_MAX_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [1:0]      i_req_type,
    input  logic [7:0]      i_rx_byte,
    input  logic [7:0]      i_group,
    input  logic [15:0]     i_run_count,
    input  logic            i_wait_for_done,
    input  logic [31:0]     i_timeout_ms,
    output logic            o_push_valid,
    output svgl_pkg::t_cmd  o_push_data,
    input  logic            i_push_ready
);

    localparam int IW = $clog2(PAYLOAD_MAX + 1);
    localparam int LW = $clog2(PAYLOAD_MAX + 2);
    localparam int CW = LW + 1;
    localparam logic [7:0] LEN_MAX = 8'(PAYLOAD_MAX + 1);

    typedef enum logic [3:0] {
        PH_HDR1 = 4'b0001,
        PH_HDR2 = 4'b0010,
        PH_LEN  = 4'b0100,
        PH_DATA = 4'b1000
    } t_phase;

    t_phase        r_phase, n_phase;
    logic [LW-1:0] r_len, n_len;
    logic [IW-1:0] r_idx, n_idx, w_idx_inc;
    logic [7:0]    r_cmd_b, n_cmd_b, r_grp_b, n_grp_b;
    logic [7:0]    r_done, n_done;
    logic          r_awaiting, n_awaiting;
    logic [7:0]    r_awaited, n_awaited;
    logic [31:0]   r_elapsed, n_elapsed, r_limit, n_limit;
    logic [31:0]   w_tick_cnt;
    logic          w_acc;
    logic          w_frame_end;
    logic          w_tmo_hit;
    svgl_pkg::t_req w_req;

    assign w_req      = svgl_pkg::t_req'(i_req_type);
    assign w_acc      = i_in_valid && i_push_ready;
    assign o_in_ready = i_push_ready;
    assign w_tick_cnt = r_elapsed + 32'd1;
    assign w_idx_inc  = r_idx + IW'(1);
    assign w_frame_end = ({{(CW - IW){1'b0}}, w_idx_inc} + CW'(1)) >= {1'b0, r_len};
    assign w_tmo_hit  = w_acc && (w_req == svgl_pkg::REQ_TICK) && r_awaiting
                        && (w_tick_cnt >= r_limit);

    always_comb begin
        n_phase    = r_phase;
        n_len      = r_len;
        n_idx      = r_idx;
        n_cmd_b    = r_cmd_b;
        n_grp_b    = r_grp_b;
        n_done     = r_done;
        n_awaiting = r_awaiting;
        n_awaited  = r_awaited;
        n_elapsed  = r_elapsed;
        n_limit    = r_limit;
        o_push_valid              = 1'b0;
        o_push_data.kind          = svgl_pkg::K_STATUS;
        o_push_data.status        = svgl_pkg::ST_OK;
        o_push_data.group         = i_group;
        o_push_data.run_count     = i_run_count;
        o_push_data.fin_group     = r_done;
        if (w_acc) begin
            unique case (w_req)
                svgl_pkg::REQ_START: begin
                    o_push_valid = 1'b1;
                    if (i_wait_for_done && (i_timeout_ms == 32'd0)) begin
                        o_push_data.status = svgl_pkg::ST_ARG;
                    end else begin
                        n_done     = svgl_pkg::NO_GROUP;
                        n_awaiting = i_wait_for_done;
                        n_awaited  = i_wait_for_done ? i_group : 8'd0;
                        n_elapsed  = 32'd0;
                        n_limit    = i_wait_for_done ? i_timeout_ms : 32'd0;
                        o_push_data.kind      = svgl_pkg::K_FRAME;
                        o_push_data.fin_group = svgl_pkg::NO_GROUP;
                    end
                end
                svgl_pkg::REQ_BYTE: begin
                    unique case (r_phase)
                        PH_HDR1: begin
                            if (i_rx_byte == svgl_pkg::HDR_BYTE) n_phase = PH_HDR2;
                        end
                        PH_HDR2: begin
                            n_phase = (i_rx_byte == svgl_pkg::HDR_BYTE) ? PH_LEN : PH_HDR1;
                        end
                        PH_LEN: begin
                            n_idx = '0;
                            if (i_rx_byte >= svgl_pkg::MIN_LEN && i_rx_byte <= LEN_MAX) begin
                                n_len   = i_rx_byte[LW-1:0];
                                n_phase = PH_DATA;
                            end else begin
                                n_len   = '0;
                                n_phase = PH_HDR1;
                            end
                        end
                        PH_DATA: begin
                            if (r_idx == IW'(0)) n_cmd_b = i_rx_byte;
                            if (r_idx == IW'(1)) n_grp_b = i_rx_byte;
                            n_idx = w_idx_inc;
                            if (w_frame_end) begin
                                if ({{(8 - LW){1'b0}}, r_len} == svgl_pkg::DONE_LEN
                                        && n_cmd_b == svgl_pkg::CMD_DONE) begin
                                    n_done = n_grp_b;
                                end
                                n_phase = PH_HDR1;
                                n_len   = '0;
                                n_idx   = '0;
                            end
                        end
                        default: begin
                            n_phase = PH_HDR1;
                            n_len   = '0;
                            n_idx   = '0;
                        end
                    endcase
                end
                svgl_pkg::REQ_LINE_ERR: begin
                    n_phase = PH_HDR1;
                    n_len   = '0;
                    n_idx   = '0;
                end
                svgl_pkg::REQ_TICK: begin
                end
            endcase
            if (w_req != svgl_pkg::REQ_START && r_awaiting) begin
                if (w_req == svgl_pkg::REQ_TICK) n_elapsed = w_tick_cnt;
                if (w_req == svgl_pkg::REQ_TICK && w_tick_cnt >= r_limit) begin
                    n_awaiting            = 1'b0;
                    o_push_valid          = 1'b1;
                    o_push_data.status    = svgl_pkg::ST_TIMEOUT;
                    o_push_data.fin_group = n_done;
                end else if (n_done == r_awaited) begin
                    n_awaiting            = 1'b0;
                    o_push_valid          = 1'b1;
                    o_push_data.fin_group = n_done;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HDR1;
            r_len      <= '0;
            r_idx      <= '0;
            r_done     <= svgl_pkg::NO_GROUP;
            r_awaiting <= 1'b0;
            r_awaited  <= 8'd0;
            r_elapsed  <= 32'd0;
            r_limit    <= 32'd0;
        end else begin
            r_phase    <= n_phase;
            r_len      <= n_len;
            r_idx      <= n_idx;
            r_done     <= n_done;
            r_awaiting <= n_awaiting;
            r_awaited  <= n_awaited;
            r_elapsed  <= n_elapsed;
            r_limit    <= n_limit;
        end
    end

    // Command and group bytes of the current frame: no reset needed.
    always_ff @(posedge i_clk) begin
        r_cmd_b <= n_cmd_b;
        r_grp_b <= n_grp_b;
    end

    `ASSERT_PROP(a_tick_timeout_ends_wait, i_clk, i_rst_n, w_tmo_hit |=> !r_awaiting)
    `ASSERT_NEVER(a_push_without_beat, i_clk, i_rst_n, o_push_valid && !w_acc)

endmodule

### rtl/core/svgl_cmdq.sv
`include "assert_macros.svh"

module svgl_cmdq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  svgl_pkg::t_cmd  i_push_data,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output svgl_pkg::t_cmd  o_pop_data
);

    localparam int DEPTH = svgl_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = $clog2(DEPTH + 1);

    svgl_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [NW-1:0]  r_count;
    logic           w_push, w_pop;

    assign o_push_ready = (r_count != NW'(DEPTH));
    assign o_pop_valid  = (r_count != NW'(0));
    assign o_pop_data   = r_mem[r_rd];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            if (w_pop)  r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            if (w_push && !w_pop)      r_count <= r_count + NW'(1);
            else if (w_pop && !w_push) r_count <= r_count - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_push_data;
    end

    `ASSERT_NEVER(a_count_over_depth, i_clk, i_rst_n, r_count > NW'(DEPTH))
    `ASSERT_PROP(a_pop_follows_push, i_clk, i_rst_n, w_push && r_count == NW'(0) |=> o_pop_valid)

endmodule

### rtl/core/svgl_back.sv
`include "assert_macros.svh"

module svgl_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_pop_valid,
    output logic            o_pop_ready,
    input  svgl_pkg::t_cmd  i_pop_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic            o_result_kind,
    output logic [7:0]      o_tx_byte,
    output logic [1:0]      o_status,
    output logic [7:0]      o_finished_group,
    output logic            o_last
);

    localparam logic [2:0] B_HDR1 = 3'd0;
    localparam logic [2:0] B_HDR2 = 3'd1;
    localparam logic [2:0] B_LEN  = 3'd2;
    localparam logic [2:0] B_CMD  = 3'd3;
    localparam logic [2:0] B_GRP  = 3'd4;
    localparam logic [2:0] B_REPL = 3'd5;
    localparam logic [2:0] B_REPH = 3'd6;

    logic           r_busy;
    logic [2:0]     r_idx;
    svgl_pkg::t_cmd r_cmd;
    logic           w_is_status;
    logic           w_beat_last;
    logic [7:0]     w_frame_byte;

    assign w_is_status = (r_cmd.kind == svgl_pkg::K_STATUS);
    assign w_beat_last = w_is_status || (r_idx == B_REPH);
    assign o_pop_ready = !r_busy || (i_out_ready && w_beat_last);

    always_comb begin
        unique case (r_idx)
            B_HDR1:  w_frame_byte = svgl_pkg::HDR_BYTE;
            B_HDR2:  w_frame_byte = svgl_pkg::HDR_BYTE;
            B_LEN:   w_frame_byte = svgl_pkg::RUN_LEN;
            B_CMD:   w_frame_byte = svgl_pkg::CMD_RUN;
            B_GRP:   w_frame_byte = r_cmd.group;
            B_REPL:  w_frame_byte = r_cmd.run_count[7:0];
            B_REPH:  w_frame_byte = r_cmd.run_count[15:8];
            default: w_frame_byte = 8'd0;
        endcase
    end

    assign o_out_valid      = r_busy;
    assign o_result_kind    = r_cmd.kind;
    assign o_tx_byte        = w_is_status ? 8'd0 : w_frame_byte;
    assign o_status         = w_is_status ? r_cmd.status : svgl_pkg::ST_OK;
    assign o_finished_group = r_cmd.fin_group;
    assign o_last           = w_beat_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= B_HDR1;
        end else if (o_pop_ready) begin
            r_busy <= i_pop_valid;
            r_idx  <= B_HDR1;
        end else if (i_out_ready) begin
            r_idx  <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop_ready && i_pop_valid) r_cmd <= i_pop_data;
    end

    `ASSERT_PROP(a_status_single_beat, i_clk, i_rst_n, r_busy && w_is_status |-> o_last)
    `ASSERT_NEVER(a_idx_past_frame, i_clk, i_rst_n, r_busy && r_idx > B_REPH)

endmodule
